FILE: src/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, widths and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

  localparam int DATA_W     = 13;
  localparam int PAGE_W     = 13;
  localparam int ALIGN_W    = 4;
  localparam int BS_W       = 13;
  localparam int BPP_W      = 10;
  localparam int ADDR_W     = 16;
  localparam int PAGES_W    = 5;
  localparam int COUNT_W    = 14;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int DEF_MAX_PAGES  = 16;
  localparam int DEF_FREE_DEPTH = 8192;

  localparam int LINK_BYTES        = 8;
  localparam int PAGE_HEADER_BYTES = 8;

  localparam int MAX_DATA_SIZE  = 4096;
  localparam int MAX_PAGE_BYTES = 4096;
  localparam int MAX_ALIGN      = 12;

  localparam int RST_DATA_SIZE  = 8;
  localparam int RST_PAGE_BYTES = 4096;
  localparam int RST_ALIGN      = 3;

  localparam int RST_MIN_SIZE   = (RST_DATA_SIZE > LINK_BYTES) ? RST_DATA_SIZE : LINK_BYTES;
  localparam int RST_BLOCK_SIZE = ((RST_MIN_SIZE + (1 << RST_ALIGN) - 1) >> RST_ALIGN)
                                  << RST_ALIGN;
  localparam int RST_BPP        = (RST_PAGE_BYTES - PAGE_HEADER_BYTES) / RST_BLOCK_SIZE;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_ALL = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_EXHAUSTED  = 2'd1,
    STAT_NO_FIT     = 2'd2,
    STAT_STACK_FULL = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_SIZE  = 2'd0,
    CFG_PAGE_BYTES = 2'd1,
    CFG_ALIGN_LOG2 = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic              busy;
    logic [BS_W-1:0]   block_size;
    logic [PAGE_W-1:0] page_bytes;
    logic [BPP_W-1:0]  blocks_per_page;
  } sizes_t;

  function automatic logic is_cfg_reg(input logic [CFG_IDX_W-1:0] idx);
    logic hit;
    hit = (idx == CFG_DATA_SIZE) || (idx == CFG_PAGE_BYTES) || (idx == CFG_ALIGN_LOG2);
    return hit;
  endfunction

endpackage

`default_nettype wire

FILE: src/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/fbpa_sizer.sv
// ----------------------------------------------------------------------------
// fbpa_sizer
// Configuration registers and block sizing. After a register write the block
// size is formed and the usable page bytes are divided by it, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_sizer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
  output fbpa_pkg::sizes_t                      sizes
);

  import fbpa_pkg::*;

  localparam int DIV_W = 12;
  localparam int CNT_W = $clog2(DIV_W);

  logic [DATA_W-1:0]  data_size_r, data_size_nxt;
  logic [PAGE_W-1:0]  page_bytes_r, page_bytes_nxt;
  logic [ALIGN_W-1:0] align_r, align_nxt;
  logic               start_r, start_nxt;
  logic               run_r, run_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BS_W-1:0]    bs_r, bs_nxt;
  logic [PAGE_W-1:0]  psat_r, psat_nxt;
  logic [BPP_W-1:0]   bpp_r, bpp_nxt;
  logic [DIV_W-1:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0]   q_r, q_nxt;

  logic [DATA_W-1:0]  ds_sat;
  logic [PAGE_W-1:0]  ps_sat;
  logic [ALIGN_W-1:0] al_sat;
  logic [BS_W-1:0]    min_size;
  logic [BS_W-1:0]    mask;
  logic [BS_W-1:0]    bs_calc;
  logic [DIV_W:0]     shifted;
  logic [DIV_W:0]     diff;
  logic               fits;
  logic [DIV_W-1:0]   q_step;

  always_comb begin
    if (data_size_r == '0) begin
      ds_sat = DATA_W'(1);
    end else if (data_size_r > DATA_W'(MAX_DATA_SIZE)) begin
      ds_sat = DATA_W'(MAX_DATA_SIZE);
    end else begin
      ds_sat = data_size_r;
    end
    ps_sat   = (page_bytes_r > PAGE_W'(MAX_PAGE_BYTES)) ? PAGE_W'(MAX_PAGE_BYTES)
                                                          : page_bytes_r;
    al_sat   = (align_r > ALIGN_W'(MAX_ALIGN)) ? ALIGN_W'(MAX_ALIGN) : align_r;
    min_size = (ds_sat > DATA_W'(LINK_BYTES)) ? BS_W'(ds_sat) : BS_W'(LINK_BYTES);
    mask     = (BS_W'(1) << al_sat) - BS_W'(1);
    bs_calc  = (min_size + mask) & ~mask;

    shifted = {rem_r, q_r[DIV_W-1]};
    fits    = (shifted >= (DIV_W+1)'(bs_r));
    diff    = shifted - (DIV_W+1)'(bs_r);
    q_step  = {q_r[DIV_W-2:0], fits};
  end

  always_comb begin
    data_size_nxt  = data_size_r;
    page_bytes_nxt = page_bytes_r;
    align_nxt      = align_r;
    start_nxt      = start_r;
    run_nxt        = run_r;
    cnt_nxt        = cnt_r;
    bs_nxt         = bs_r;
    psat_nxt       = psat_r;
    bpp_nxt        = bpp_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    if (cfg_we && is_cfg_reg(cfg_index)) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DATA_SIZE:  data_size_nxt  = cfg_data[DATA_W-1:0];
        CFG_PAGE_BYTES: page_bytes_nxt = cfg_data[PAGE_W-1:0];
        CFG_ALIGN_LOG2: align_nxt      = cfg_data[ALIGN_W-1:0];
        default:        data_size_nxt  = data_size_r;
      endcase
      start_nxt = 1'b1;
      run_nxt   = 1'b0;
    end else if (start_r) begin
      start_nxt = 1'b0;
      bs_nxt    = bs_calc;
      psat_nxt  = ps_sat;
      if (ps_sat > PAGE_W'(PAGE_HEADER_BYTES)) begin
        rem_nxt = '0;
        q_nxt   = DIV_W'(ps_sat - PAGE_W'(PAGE_HEADER_BYTES));
        cnt_nxt = '0;
        run_nxt = 1'b1;
      end else begin
        bpp_nxt = '0;
      end
    end else if (run_r) begin
      rem_nxt = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      q_nxt   = q_step;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        run_nxt = 1'b0;
        bpp_nxt = q_step[BPP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_size_r  <= DATA_W'(RST_DATA_SIZE);
      page_bytes_r <= PAGE_W'(RST_PAGE_BYTES);
      align_r      <= ALIGN_W'(RST_ALIGN);
      start_r      <= 1'b0;
      run_r        <= 1'b0;
      cnt_r        <= '0;
      bs_r         <= BS_W'(RST_BLOCK_SIZE);
      psat_r       <= PAGE_W'(RST_PAGE_BYTES);
      bpp_r        <= BPP_W'(RST_BPP);
    end else begin
      data_size_r  <= data_size_nxt;
      page_bytes_r <= page_bytes_nxt;
      align_r      <= align_nxt;
      start_r      <= start_nxt;
      run_r        <= run_nxt;
      cnt_r        <= cnt_nxt;
      bs_r         <= bs_nxt;
      psat_r       <= psat_nxt;
      bpp_r        <= bpp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign sizes.busy            = start_r | run_r;
  assign sizes.block_size      = bs_r;
  assign sizes.page_bytes      = psat_r;
  assign sizes.blocks_per_page = bpp_r;

endmodule

`default_nettype wire

FILE: src/fixed_block_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Fixed-size block allocator over a 64 KiB byte pool. Freed addresses sit in
// a LIFO stack held in RAM; fresh blocks are handed out page by page.
//
//   Channel   Direction   Handshake            Payload
//   in_       in          in_valid/in_ready    operation, free_addr
//   out_      out         out_valid/out_ready  status, block_addr, counts
//   cfg_      in          cfg_we               cfg_index, cfg_data
//
// In each transaction the accept cycle issues the stack read; the execute state
// then updates the state and loads the output register.
// A new transaction is accepted while the previous result waits in the output
// register; execution holds while that register is still full.
// A register write restarts sizing: in_ready is low while the one-bit-per-cycle
// divider runs. The pool is emptied on the write itself.
// Reset is synchronous; the free stack RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator_unit #(
  parameter int MAX_PAGES  = fbpa_pkg::DEF_MAX_PAGES,
  parameter int FREE_DEPTH = fbpa_pkg::DEF_FREE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [fbpa_pkg::OP_W-1:0]        in_operation,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]      in_free_addr,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [fbpa_pkg::STATUS_W-1:0]    out_status,
  output logic      [fbpa_pkg::ADDR_W-1:0]      out_block_addr,
  output logic      [fbpa_pkg::PAGES_W-1:0]     out_pages_in_use,
  output logic      [fbpa_pkg::COUNT_W-1:0]     out_total_blocks,
  output logic      [fbpa_pkg::COUNT_W-1:0]     out_free_blocks,
  input  wire logic                             cfg_we,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import fbpa_pkg::*;

  localparam int SC_W  = $clog2(FREE_DEPTH + 1);
  localparam int RA_W  = $clog2(FREE_DEPTH);
  localparam int PG_W  = $clog2(MAX_PAGES + 1);
  localparam int PR_W  = PG_W + PAGE_W;
  localparam int NA_W  = (PR_W > ADDR_W) ? PR_W : ADDR_W;
  localparam int PGX_W = (PG_W > PAGES_W) ? PG_W : PAGES_W;
  localparam int TP_W  = PG_W + BPP_W;
  localparam int TB_W  = (TP_W > COUNT_W) ? TP_W : COUNT_W;
  localparam int AS_W  = ((SC_W > BPP_W) ? SC_W : BPP_W) + 1;
  localparam int AV_W  = (AS_W > COUNT_W) ? AS_W : COUNT_W;

  sizes_t             sizes;
  fsm_t               state_r, state_nxt;
  op_t                op_r;
  logic [ADDR_W-1:0]  faddr_r;
  logic [SC_W-1:0]    stack_count_r, stack_count_nxt;
  logic [ADDR_W-1:0]  fresh_addr_r, fresh_addr_nxt;
  logic [BPP_W-1:0]   fresh_left_r, fresh_left_nxt;
  logic [PG_W-1:0]    pages_open_r, pages_open_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, status_nxt;
  logic [ADDR_W-1:0]  out_addr_r, addr_nxt;
  logic [PAGES_W-1:0] out_pages_r, pages_out_nxt;
  logic [COUNT_W-1:0] out_total_r, total_nxt;
  logic [COUNT_W-1:0] out_free_r, free_nxt;

  logic               accept;
  logic               out_free;
  logic               exec_fire;
  logic               cfg_hit;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_rdata;
  logic [RA_W-1:0]    ram_raddr;
  logic [PR_W-1:0]    page_base;
  logic [NA_W-1:0]    new_addr_wide;
  logic [ADDR_W-1:0]  new_addr;
  logic [PGX_W-1:0]   pages_x;
  logic [TB_W-1:0]    total_x;
  logic [AV_W-1:0]    avail_x;

  fbpa_sizer u_sizer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sizes     (sizes)
  );

  fbpa_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (FREE_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stack_count_r[RA_W-1:0]),
    .wdata (faddr_r),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_hit   = cfg_we && is_cfg_reg(cfg_index);
  assign out_free  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign ram_raddr = RA_W'(stack_count_r - SC_W'(1));

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = out_free ? ST_IDLE : ST_EXEC;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = !sizes.busy;
        exec_fire = 1'b0;
      end
      ST_EXEC: begin
        in_ready  = 1'b0;
        exec_fire = out_free;
      end
      default: begin
        in_ready  = 1'b0;
        exec_fire = 1'b0;
      end
    endcase
  end

  always_comb begin
    page_base     = PR_W'(pages_open_r) * PR_W'(sizes.page_bytes);
    new_addr_wide = NA_W'(page_base) + NA_W'(PAGE_HEADER_BYTES);
    new_addr      = new_addr_wide[ADDR_W-1:0];

    stack_count_nxt = stack_count_r;
    fresh_addr_nxt  = fresh_addr_r;
    fresh_left_nxt  = fresh_left_r;
    pages_open_nxt  = pages_open_r;
    status_nxt      = STAT_OK;
    addr_nxt        = '0;
    ram_we          = 1'b0;

    if (exec_fire) begin
      case (op_r)
        OP_ALLOC: begin
          if (stack_count_r != '0) begin
            stack_count_nxt = stack_count_r - SC_W'(1);
            addr_nxt        = ram_rdata;
          end else if (fresh_left_r != '0) begin
            addr_nxt       = fresh_addr_r;
            fresh_addr_nxt = fresh_addr_r + ADDR_W'(sizes.block_size);
            fresh_left_nxt = fresh_left_r - BPP_W'(1);
          end else if (sizes.blocks_per_page == '0) begin
            status_nxt = STAT_NO_FIT;
          end else if (pages_open_r >= PG_W'(MAX_PAGES)) begin
            status_nxt = STAT_EXHAUSTED;
          end else begin
            addr_nxt       = new_addr;
            fresh_addr_nxt = new_addr + ADDR_W'(sizes.block_size);
            fresh_left_nxt = sizes.blocks_per_page - BPP_W'(1);
            pages_open_nxt = pages_open_r + PG_W'(1);
          end
        end
        OP_FREE: begin
          if (stack_count_r >= SC_W'(FREE_DEPTH)) begin
            status_nxt = STAT_STACK_FULL;
          end else begin
            ram_we          = 1'b1;
            stack_count_nxt = stack_count_r + SC_W'(1);
          end
        end
        OP_FREE_ALL: begin
          stack_count_nxt = '0;
          fresh_addr_nxt  = '0;
          fresh_left_nxt  = '0;
          pages_open_nxt  = '0;
        end
        default: begin
          status_nxt = STAT_OK;
        end
      endcase
    end

    pages_x       = PGX_W'(pages_open_nxt);
    pages_out_nxt = pages_x[PAGES_W-1:0];
    total_x       = TB_W'(TP_W'(pages_open_nxt) * TP_W'(sizes.blocks_per_page));
    total_nxt     = total_x[COUNT_W-1:0];
    avail_x       = AV_W'(stack_count_nxt) + AV_W'(fresh_left_nxt);
    free_nxt      = avail_x[COUNT_W-1:0];

    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      stack_count_r <= '0;
      fresh_addr_r  <= '0;
      fresh_left_r  <= '0;
      pages_open_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_hit) begin
        stack_count_r <= '0;
        fresh_addr_r  <= '0;
        fresh_left_r  <= '0;
        pages_open_r  <= '0;
      end else begin
        stack_count_r <= stack_count_nxt;
        fresh_addr_r  <= fresh_addr_nxt;
        fresh_left_r  <= fresh_left_nxt;
        pages_open_r  <= pages_open_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(in_operation);
      faddr_r <= in_free_addr;
    end
    if (exec_fire) begin
      out_status_r <= status_nxt;
      out_addr_r   <= addr_nxt;
      out_pages_r  <= pages_out_nxt;
      out_total_r  <= total_nxt;
      out_free_r   <= free_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_addr   = out_addr_r;
  assign out_pages_in_use = out_pages_r;
  assign out_total_blocks = out_total_r;
  assign out_free_blocks  = out_free_r;

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_count_r <= SC_W'(FREE_DEPTH))
    else $error("Free stack count exceeds its depth.");

  a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pages_open_r <= PG_W'(MAX_PAGES))
    else $error("Open page count exceeds the page limit.");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fresh_left_r != '0) |-> (fresh_left_r < sizes.blocks_per_page))
    else $error("Fresh block count exceeds the blocks in one page.");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EXEC))
    else $error("A result appeared without an executed transaction.");

endmodule

`default_nettype wire

FILE: test/tb_fixed_block_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator_unit
// Self-checking bench for the fixed block pool allocator. A short table of
// directed transactions covers reset values, the register extremes, pool
// exhaustion, pages too small for a block and the ignored register index.
// Random transactions follow under changing pool geometries, mostly
// allocate and free of live blocks, with some stray frees and free-alls.
// Every result is checked field by field, against the expected values of the
// typed table rows or else against an in-bench prediction of the pool state.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fixed_block_pool_allocator_unit;
  import fbpa_pkg::*;

  localparam int HALF_PERIOD      = 6;
  localparam int RUN_LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES      = 400;
  localparam int MAX_REPORTS      = 100;

  localparam logic [OP_W-1:0]      OP_UNUSED      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    status_t              status;
    logic [ADDR_W-1:0]    block_addr;
    logic [PAGES_W-1:0]   pages;
    logic [COUNT_W-1:0]   total;
    logic [COUNT_W-1:0]   avail;
  } pool_result_t;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_value;
    logic [OP_W-1:0]         op;
    logic [ADDR_W-1:0]       addr;
    int                      reps;
    bit                      typed;
    pool_result_t            want;
  } plan_row_t;

  localparam pool_result_t NO_WANT = '{STAT_OK, 16'h0000, 5'd0, 14'd0, 14'd0};

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         in_operation = '0;
  logic [ADDR_W-1:0]       in_free_addr = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic [ADDR_W-1:0]       out_block_addr;
  logic [PAGES_W-1:0]      out_pages_in_use;
  logic [COUNT_W-1:0]      out_total_blocks;
  logic [COUNT_W-1:0]      out_free_blocks;
  logic                    cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index    = '0;
  logic [CFG_DATA_W-1:0]   cfg_data     = '0;

  fixed_block_pool_allocator_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_free_addr     (in_free_addr),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_block_addr   (out_block_addr),
    .out_pages_in_use (out_pages_in_use),
    .out_total_blocks (out_total_blocks),
    .out_free_blocks  (out_free_blocks),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Predicted pool state.
  logic [ADDR_W-1:0] free_lifo [DEF_FREE_DEPTH];
  int unsigned       lifo_depth;
  int unsigned       fresh_ptr;
  int unsigned       fresh_left;
  int unsigned       pages_opened;
  int unsigned       blk_size;
  int unsigned       blk_per_page;
  int unsigned       reg_data_size;
  int unsigned       reg_page_bytes;
  int unsigned       reg_align;

  pool_result_t      pool_results_due [$];
  logic [ADDR_W-1:0] live_blocks [$];

  int  err_count;
  int  cycle_count;
  int  send_idle;
  int  recv_idle;
  int  hold_left;
  bit  hold_req;

  plan_row_t directed_plan [23] = '{
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_ALLOC, 16'h0000, 1, 1'b1,
      '{STAT_OK, 16'h0008, 5'd1, 14'd511, 14'd510}},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_FREE, 16'hFFFF, 1, 1'b1,
      '{STAT_OK, 16'h0000, 5'd1, 14'd511, 14'd511}},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_ALLOC, 16'h0000, 1, 1'b1,
      '{STAT_OK, 16'hFFFF, 5'd1, 14'd511, 14'd510}},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_UNUSED, 16'h5555, 1, 1'b1,
      '{STAT_OK, 16'h0000, 5'd1, 14'd511, 14'd510}},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_FREE_ALL, 16'hAAAA, 1, 1'b1,
      '{STAT_OK, 16'h0000, 5'd0, 14'd0, 14'd0}},
    '{ROW_CFG, CFG_DATA_SIZE, 13'd2048, OP_ALLOC, 16'h0000, 0, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_ALIGN_LOG2, 13'd0, OP_ALLOC, 16'h0000, 0, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_ALLOC, 16'h0000, 16, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_ALLOC, 16'h0000, 1, 1'b1,
      '{STAT_EXHAUSTED, 16'h0000, 5'd16, 14'd16, 14'd0}},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_FREE, 16'h1234, 1, 1'b1,
      '{STAT_OK, 16'h0000, 5'd16, 14'd16, 14'd1}},
    '{ROW_CFG, CFG_PAGE_BYTES, 13'd8, OP_ALLOC, 16'h0000, 0, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_ALLOC, 16'h0000, 1, 1'b1,
      '{STAT_NO_FIT, 16'h0000, 5'd0, 14'd0, 14'd0}},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_FREE, 16'h00F0, 1, 1'b1,
      '{STAT_OK, 16'h0000, 5'd0, 14'd0, 14'd1}},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_ALLOC, 16'h0000, 1, 1'b1,
      '{STAT_OK, 16'h00F0, 5'd0, 14'd0, 14'd0}},
    '{ROW_CFG, CFG_DATA_SIZE, 13'd0, OP_ALLOC, 16'h0000, 0, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_PAGE_BYTES, 13'd16, OP_ALLOC, 16'h0000, 0, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_ALLOC, 16'h0000, 2, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_UNUSED_IDX, 13'h1FFF, OP_ALLOC, 16'h0000, 0, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_ALLOC, 16'h0000, 1, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_DATA_SIZE, 13'h1FFF, OP_ALLOC, 16'h0000, 0, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_PAGE_BYTES, 13'h1FFF, OP_ALLOC, 16'h0000, 0, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_ALIGN_LOG2, 13'h1FFF, OP_ALLOC, 16'h0000, 0, 1'b0, NO_WANT},
    '{ROW_ITEM, CFG_DATA_SIZE, 13'd0, OP_ALLOC, 16'h0000, 1, 1'b1,
      '{STAT_NO_FIT, 16'h0000, 5'd0, 14'd0, 14'd0}}
  };

  function automatic int unsigned clamped_page_bytes();
    return (reg_page_bytes > MAX_PAGE_BYTES) ? MAX_PAGE_BYTES : reg_page_bytes;
  endfunction

  function automatic void empty_pool();
    lifo_depth   = 0;
    fresh_ptr    = 0;
    fresh_left   = 0;
    pages_opened = 0;
  endfunction

  function automatic void recompute_geometry();
    int unsigned ds;
    int unsigned ps;
    int unsigned al;
    int unsigned need;
    int unsigned mask;
    ds = reg_data_size;
    if (ds < 1) ds = 1;
    if (ds > MAX_DATA_SIZE) ds = MAX_DATA_SIZE;
    ps   = clamped_page_bytes();
    al   = (reg_align > MAX_ALIGN) ? MAX_ALIGN : reg_align;
    need = (ds > LINK_BYTES) ? ds : LINK_BYTES;
    mask = (1 << al) - 1;
    blk_size = (need + mask) & ~mask;
    if (ps > PAGE_HEADER_BYTES) begin
      blk_per_page = (ps - PAGE_HEADER_BYTES) / blk_size;
    end else begin
      blk_per_page = 0;
    end
  endfunction

  function automatic void pool_reset();
    reg_data_size  = RST_DATA_SIZE;
    reg_page_bytes = RST_PAGE_BYTES;
    reg_align      = RST_ALIGN;
    empty_pool();
    recompute_geometry();
  endfunction

  function automatic void pool_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_DATA_SIZE:  reg_data_size  = value;
      CFG_PAGE_BYTES: reg_page_bytes = value;
      CFG_ALIGN_LOG2: reg_align      = value[ALIGN_W-1:0];
      default:        return;
    endcase
    recompute_geometry();
    empty_pool();
  endfunction

  function automatic pool_result_t pool_next_result(input logic [OP_W-1:0] op,
                                                    input logic [ADDR_W-1:0] faddr);
    pool_result_t r;
    int unsigned  base;
    r = NO_WANT;
    case (op)
      OP_ALLOC: begin
        if (lifo_depth > 0) begin
          lifo_depth--;
          r.block_addr = free_lifo[lifo_depth];
        end else if (fresh_left > 0) begin
          r.block_addr = fresh_ptr[ADDR_W-1:0];
          fresh_ptr    = (fresh_ptr + blk_size) & 16'hFFFF;
          fresh_left--;
        end else if (blk_per_page == 0) begin
          r.status = STAT_NO_FIT;
        end else if (pages_opened >= DEF_MAX_PAGES) begin
          r.status = STAT_EXHAUSTED;
        end else begin
          base         = (pages_opened * clamped_page_bytes() + PAGE_HEADER_BYTES) & 16'hFFFF;
          r.block_addr = base[ADDR_W-1:0];
          fresh_ptr    = (base + blk_size) & 16'hFFFF;
          fresh_left   = blk_per_page - 1;
          pages_opened++;
        end
      end
      OP_FREE: begin
        if (lifo_depth >= DEF_FREE_DEPTH) begin
          r.status = STAT_STACK_FULL;
        end else begin
          free_lifo[lifo_depth] = faddr;
          lifo_depth++;
        end
      end
      OP_FREE_ALL: begin
        empty_pool();
      end
      default: begin
      end
    endcase
    r.pages = pages_opened[PAGES_W-1:0];
    r.total = COUNT_W'(pages_opened * blk_per_page);
    r.avail = COUNT_W'(lifo_depth + fresh_left);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    if (err_count < MAX_REPORTS) begin
      $display("MISMATCH %s: got 0x%h, expected 0x%h", what, got, want);
    end
    err_count++;
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input bit typed, input pool_result_t fixed_want);
    pool_result_t due;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_free_addr <= addr;
    do @(posedge clk); while (!in_ready);
    due = pool_next_result(op, addr);
    if (op == OP_ALLOC && due.status == STAT_OK) live_blocks.push_back(due.block_addr);
    if (op == OP_FREE_ALL) live_blocks.delete();
    if (typed) due = fixed_want;
    pool_results_due.push_back(due);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pool_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_write_reg(idx, value);
    if (idx != CFG_UNUSED_IDX) live_blocks.delete();
    repeat (2) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic random_geometry();
    logic [CFG_DATA_W-1:0] ds;
    logic [CFG_DATA_W-1:0] ps;
    logic [CFG_DATA_W-1:0] al;
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) ds = CFG_DATA_W'($urandom_range(4097, 8191));
    else if (pick == 1) ds = CFG_DATA_W'($urandom_range(0, 8));
    else ds = CFG_DATA_W'($urandom_range(1, 200));
    pick = $urandom_range(9);
    if (pick == 0) ps = CFG_DATA_W'($urandom_range(0, 16));
    else if (pick == 1) ps = CFG_DATA_W'($urandom_range(4097, 8191));
    else ps = CFG_DATA_W'($urandom_range(16, 600));
    if ($urandom_range(6) == 0) al = CFG_DATA_W'($urandom_range(0, 8191));
    else al = CFG_DATA_W'($urandom_range(0, 6));
    write_reg(CFG_DATA_SIZE, ds);
    write_reg(CFG_PAGE_BYTES, ps);
    write_reg(CFG_ALIGN_LOG2, al);
  endtask

  task automatic random_item();
    int               pick;
    int               slot;
    logic [OP_W-1:0]  op;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(99);
    addr = ADDR_W'($urandom());
    if (pick < 55) begin
      op = OP_ALLOC;
    end else if (pick < 90) begin
      op = OP_FREE;
      if (live_blocks.size() != 0 && $urandom_range(9) < 8) begin
        slot = $urandom_range(live_blocks.size() - 1);
        addr = live_blocks[slot];
        live_blocks.delete(slot);
      end
    end else if (pick < 96) begin
      op = OP_FREE_ALL;
    end else begin
      op = OP_UNUSED;
    end
    send_item(op, addr, 1'b0, NO_WANT);
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    pool_result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (pool_results_due.size() == 0) begin
        report_mismatch("result with nothing pending", out_block_addr, 16'h0000);
      end else begin
        due = pool_results_due.pop_front();
        if (out_status !== due.status)
          report_mismatch("status", ADDR_W'(out_status), ADDR_W'(due.status));
        if (out_block_addr !== due.block_addr)
          report_mismatch("block_addr", out_block_addr, due.block_addr);
        if (out_pages_in_use !== due.pages)
          report_mismatch("pages_in_use", ADDR_W'(out_pages_in_use), ADDR_W'(due.pages));
        if (out_total_blocks !== due.total)
          report_mismatch("total_blocks", ADDR_W'(out_total_blocks), ADDR_W'(due.total));
        if (out_free_blocks !== due.avail)
          report_mismatch("free_blocks", ADDR_W'(out_free_blocks), ADDR_W'(due.avail));
      end
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    err_count = 0;
    hold_left = 0;
    hold_req  = 1'b0;
    send_idle = 30;
    recv_idle = 83;
    pool_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_value);
      end else begin
        repeat (directed_plan[i].reps)
          send_item(directed_plan[i].op, directed_plan[i].addr,
                    directed_plan[i].typed, directed_plan[i].want);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle = 30;
          recv_idle = 83;
        end
        1: begin
          send_idle = 83;
          recv_idle = 30;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int seg = 0; seg < 6; seg++) begin
        wait_idle();
        random_geometry();
        if (seg == 0) hold_req = 1'b1;
        repeat (85) random_item();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (err_count == 0 && pool_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
src/fbpa_pkg.sv
src/fbpa_ram.sv
src/fbpa_sizer.sv
src/fixed_block_pool_allocator_unit.sv
test/tb_fixed_block_pool_allocator_unit.sv
